[hdl/strd_pkg.sv]
// shared types, constants and tables for the six-bit tape record deframer
// no dependencies
package strd_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 3840;
  localparam int unsigned MIN_BLOCK_BYTES = 6;
  localparam int unsigned MARKER_CHARS    = 7;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned LEN_W   = 12;
  localparam int unsigned LENC_W  = 13;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned BLK_W   = 16;
  localparam int unsigned MIDX_W  = 4;
  localparam int unsigned QUOT_W  = 10;

  // floor(x/15) for x < 2**14 as (x * RCP15) >> RCP15_SH
  localparam int unsigned RCP15    = 69906;
  localparam int unsigned RCP15_SH = 20;

  // register indexes of the configuration port
  localparam logic REG_BINARY = 1'b0;
  localparam logic REG_CODED  = 1'b1;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [CHAR_W-1:0] MARKER_TBL [8] = '{
    6'o55, 6'o23, 6'o35, 6'o52, 6'o27, 6'o54, 6'o00, 6'o00
  };

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_value;
    logic              marker_ok;
    logic [CHAR_W-1:0] record_level;
    logic [BLK_W-1:0]  blocks;
  } strd_res_t;

  // all results caused by one byte, cnt of them valid
  typedef struct packed {
    logic [1:0]           cnt;
    strd_res_t [2:0]      res;
  } strd_bundle_t;

endpackage

[hdl/strd_if.sv]
// channel interfaces: input bytes, results and configuration writes
// depends on strd_pkg
interface strd_in_if import strd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic [LEN_W-1:0]  block_length;
  logic              block_end;
  modport source (output valid, data_byte, block_length, block_end, input ready);
  modport sink (input valid, data_byte, block_length, block_end, output ready);
endinterface

interface strd_out_if import strd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [CHAR_W-1:0] char_value;
  logic              marker_ok;
  logic [CHAR_W-1:0] record_level;
  logic [BLK_W-1:0]  blocks_in_record;
  logic              last;
  modport source (output valid, result_kind, char_value, marker_ok, record_level,
                  blocks_in_record, last, input ready);
  modport sink (input valid, result_kind, char_value, marker_ok, record_level,
                blocks_in_record, last, output ready);
endinterface

interface strd_cfg_if import strd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [LEN_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/strd_front.sv]
// front end: length classification, unpacking, marker check and counters
// depends on strd_pkg and strd_if; feeds result bundles to strd_queue
module strd_front import strd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  strd_in_if.sink      in_ch,
  strd_cfg_if.sink     cfg_ch,
  output logic         push,
  output strd_bundle_t push_bundle,
  input  logic         q_full
);

  logic [LEN_W-1:0] bin_len_r, cod_len_r;

  // stage 1 registers
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic [LENC_W-1:0] s1_len_r;
  logic              s1_end_r;
  logic              s1_last_r;
  logic [QUOT_W-1:0] s1_quot_r;

  // block and record state
  logic [LEN_W-1:0]  bpos_r, bpos_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [CHAR_W-1:0] carry_r, carry_nxt;
  logic [CNT_W-1:0]  cdone_r, cdone_nxt;
  logic [MIDX_W-1:0] midx_r, midx_nxt;
  logic              mmatch_r, mmatch_nxt;
  logic [BLK_W-1:0]  bcnt_r, bcnt_nxt;

  logic              noise;
  logic [LENC_W-1:0] len_c;
  logic [13:0]       len2;
  logic [30:0]       prod;
  logic              consume;
  logic [CNT_W-1:0]  limit;
  strd_bundle_t      bundle;

  assign cfg_ch.ready = 1'b1;
  assign consume      = s1_valid_r && !q_full;
  assign in_ch.ready  = !s1_valid_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_len_r <= LEN_W'(3840);
      cod_len_r <= LEN_W'(960);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BINARY: bin_len_r <= cfg_ch.data;
        REG_CODED:  cod_len_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // stage 1: drop noise blocks, clamp length, full/last classification, data count quotient
  assign noise = in_ch.block_length < LEN_W'(MIN_BLOCK_BYTES);
  assign len_c = ({1'b0, in_ch.block_length} > LENC_W'(MAX_BLOCK_BYTES)) ?
                 LENC_W'(MAX_BLOCK_BYTES) : {1'b0, in_ch.block_length};
  assign len2  = {len_c, 1'b0};
  assign prod  = 31'(len2) * 31'(RCP15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= !noise;
    end else if (consume) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_len_r  <= len_c;
      s1_end_r  <= in_ch.block_end;
      s1_last_r <= (len_c != {1'b0, bin_len_r}) && (len_c != {1'b0, cod_len_r});
      s1_quot_r <= prod[RCP15_SH +: QUOT_W];
    end
  end

  assign limit = CNT_W'({s1_quot_r, 3'b000}) + CNT_W'({s1_quot_r, 1'b0});

  // stage 2: state update and result generation
  always_comb begin
    logic [CHAR_W-1:0] chars [2];
    logic [1:0]        nchar;
    logic [1:0]        n;
    strd_res_t         r;
    chars[0]   = '0;
    chars[1]   = '0;
    nchar      = '0;
    n          = '0;
    r          = '0;
    bundle     = '0;
    bpos_nxt   = bpos_r;
    phase_nxt  = phase_r;
    carry_nxt  = carry_r;
    cdone_nxt  = cdone_r;
    midx_nxt   = midx_r;
    mmatch_nxt = mmatch_r;
    bcnt_nxt   = bcnt_r;

    if ({1'b0, bpos_r} < s1_len_r) begin
      case (phase_r)
        2'd0: begin
          chars[0]  = s1_byte_r[7:2];
          nchar     = 2'd1;
          carry_nxt = {s1_byte_r[1:0], 4'b0000};
          phase_nxt = 2'd1;
        end
        2'd1: begin
          chars[0]  = carry_r | {2'b00, s1_byte_r[7:4]};
          nchar     = 2'd1;
          carry_nxt = {s1_byte_r[3:0], 2'b00};
          phase_nxt = 2'd2;
        end
        default: begin
          chars[0]  = carry_r | {4'b0000, s1_byte_r[7:6]};
          chars[1]  = s1_byte_r[5:0];
          nchar     = 2'd2;
          carry_nxt = '0;
          phase_nxt = 2'd0;
        end
      endcase
    end

    for (int j = 0; j < 2; j++) begin
      if (2'(j) < nchar) begin
        if (cdone_nxt < limit) begin
          r              = '0;
          r.kind         = KIND_DATA;
          r.char_value   = chars[j];
          bundle.res[n]  = r;
          n              = n + 2'd1;
          cdone_nxt      = cdone_nxt + CNT_W'(1);
        end else if (s1_last_r && midx_nxt <= MIDX_W'(MARKER_CHARS)) begin
          if (midx_nxt < MIDX_W'(MARKER_CHARS)) begin
            if (chars[j] != MARKER_TBL[midx_nxt[2:0]]) mmatch_nxt = 1'b0;
            midx_nxt = midx_nxt + MIDX_W'(1);
          end else begin
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.marker_ok    = mmatch_nxt;
            r.record_level = mmatch_nxt ? chars[j] : '0;
            r.blocks       = (bcnt_nxt != '1) ? bcnt_nxt + BLK_W'(1) : bcnt_nxt;
            bundle.res[n]  = r;
            n              = n + 2'd1;
            bcnt_nxt       = '0;
            midx_nxt       = MIDX_W'(MARKER_CHARS + 1);
          end
        end
      end
    end

    if (bpos_r != '1) bpos_nxt = bpos_r + LEN_W'(1);

    if (s1_end_r) begin
      if (s1_last_r) begin
        if (midx_nxt <= MIDX_W'(MARKER_CHARS)) begin
          // block ran out before marker and level were complete
          r             = '0;
          r.kind        = KIND_SUMMARY;
          r.blocks      = (bcnt_nxt != '1) ? bcnt_nxt + BLK_W'(1) : bcnt_nxt;
          bundle.res[n] = r;
          n             = n + 2'd1;
          bcnt_nxt      = '0;
        end
      end else if (bcnt_nxt != '1) begin
        bcnt_nxt = bcnt_nxt + BLK_W'(1);
      end
      bpos_nxt   = '0;
      phase_nxt  = '0;
      carry_nxt  = '0;
      cdone_nxt  = '0;
      midx_nxt   = '0;
      mmatch_nxt = 1'b1;
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r   <= '0;
      phase_r  <= '0;
      carry_r  <= '0;
      cdone_r  <= '0;
      midx_r   <= '0;
      mmatch_r <= 1'b1;
      bcnt_r   <= '0;
    end else if (consume) begin
      bpos_r   <= bpos_nxt;
      phase_r  <= phase_nxt;
      carry_r  <= carry_nxt;
      cdone_r  <= cdone_nxt;
      midx_r   <= midx_nxt;
      mmatch_r <= mmatch_nxt;
      bcnt_r   <= bcnt_nxt;
    end
  end

  assign push        = consume && (bundle.cnt != 2'd0);
  assign push_bundle = bundle;

endmodule

[hdl/strd_queue.sv]
// small fifo of result bundles between front and back end
// depends on strd_pkg
module strd_queue import strd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  strd_bundle_t push_bundle,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output strd_bundle_t pop_bundle
);

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  strd_bundle_t      mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push, do_pop;

  assign full       = fill_r == FILL_W'(DEPTH);
  assign not_empty  = fill_r != '0;
  assign do_push    = push && !full;
  assign do_pop     = pop && not_empty;
  assign pop_bundle = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + FILL_W'(1);
        2'b01:   fill_r <= fill_r - FILL_W'(1);
        default: ;
      endcase
    end
  end

endmodule

[hdl/strd_back.sv]
// back end: holds one bundle and, while out_ch.ready is high, hands its results out one per cycle
// depends on strd_pkg and strd_if; drains strd_queue
module strd_back import strd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         not_empty,
  input  strd_bundle_t pop_bundle,
  output logic         pop,
  strd_out_if.source   out_ch
);

  strd_bundle_t cur_r;
  logic         cur_valid_r;
  logic [1:0]   idx_r;
  logic         at_end;
  strd_res_t    sel;

  assign at_end = idx_r == (cur_r.cnt - 2'd1);
  assign pop    = not_empty && (!cur_valid_r || (out_ch.ready && at_end));

  always_comb begin
    case (idx_r)
      2'd0:    sel = cur_r.res[0];
      2'd1:    sel = cur_r.res[1];
      default: sel = cur_r.res[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (cur_valid_r && out_ch.ready) begin
      if (at_end) begin
        cur_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= pop_bundle;
  end

  assign out_ch.valid            = cur_valid_r;
  assign out_ch.result_kind      = sel.kind;
  assign out_ch.char_value       = sel.char_value;
  assign out_ch.marker_ok        = sel.marker_ok;
  assign out_ch.record_level     = sel.record_level;
  assign out_ch.blocks_in_record = sel.blocks;
  assign out_ch.last             = at_end;

endmodule

[hdl/sixbit_tape_record_deframer.sv]
// top level of the six-bit tape record deframer
// depends on strd_pkg, strd_if, strd_front, strd_queue and strd_back
//
// usage:
//   in_ch   takes one tape byte per item with its block length tag and an end
//           mark on the block's final byte; ready is high whenever the front
//           stage is empty or the bundle queue has room
//   out_ch  gives data characters and record-end summaries; last marks the
//           final result caused by one input byte
//   cfg_ch  writes the binary (index 0) and coded (index 1) full block lengths;
//           always ready, write only while the block is idle
// path: stage 1 registers, then the bundle queue, then the output stage register
// throughput: one byte per cycle while each byte yields at most one result and
//   out_ch.ready is high; the output side hands out one result per cycle, so the
//   extra results of a byte that completes a group (two characters) or closes a
//   record are absorbed by the bundle queue
// reset (rst_n low, synchronous): lengths go to 3840 and 960, block and record
//   state clear, queue and output stage empty
// stall: with out_ch.ready low the output stage holds, the queue fills, and
//   then in_ch.ready drops; nothing is lost or repeated
module sixbit_tape_record_deframer import strd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  strd_in_if.sink     in_ch,
  strd_out_if.source  out_ch,
  strd_cfg_if.sink    cfg_ch
);

  // front to queue
  logic         push;
  strd_bundle_t push_bundle;
  logic         q_full;

  // queue to back
  logic         pop;
  logic         not_empty;
  strd_bundle_t pop_bundle;

  // classification, unpacking, marker compare and block counting
  strd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .push        (push),
    .push_bundle (push_bundle),
    .q_full      (q_full)
  );

  // decouples byte intake from result delivery
  strd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop         (pop),
    .not_empty   (not_empty),
    .pop_bundle  (pop_bundle)
  );

  // serializes each bundle onto the result channel
  strd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .pop_bundle (pop_bundle),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
